[design/dead_flag_write_marker_unit_assert.svh]
// assertion macros for the dead flag write marker unit
// used by the top level only, no other dependencies
`ifndef DEAD_FLAG_WRITE_MARKER_UNIT_ASSERT_SVH
`define DEAD_FLAG_WRITE_MARKER_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define DFWM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfwm assertion failed");

// next-cycle implication, also checked during reset
`define DFWM_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dfwm assertion failed");

`endif

[design/dfwm_pkg.sv]
// shared types, codes and the mnemonic effect table of the dead flag write marker
// no dependencies
package dfwm_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int IDX_PORT_W     = 16;
  localparam int NUM_FLAGS      = 4;
  localparam int NUM_MNEMONICS  = 73;

  // flag positions
  localparam int FLAG_CARRY    = 0;
  localparam int FLAG_OVERFLOW = 1;
  localparam int FLAG_SIGN     = 2;
  localparam int FLAG_ZERO     = 3;

  // item kinds
  localparam logic [1:0] CMD_PROC_START = 2'd0;
  localparam logic [1:0] CMD_INSN       = 2'd1;
  localparam logic [1:0] CMD_PROC_END   = 2'd2;
  localparam logic [1:0] CMD_OTHER      = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN_MNEM = 2'd1;
  localparam logic [1:0] ERR_END_NO_START = 2'd2;

  typedef enum logic [1:0] {
    EFF_IGN = 2'd0,
    EFF_RD  = 2'd1,
    EFF_WR  = 2'd2,
    EFF_RW  = 2'd3
  } eff_t;

  typedef eff_t [NUM_FLAGS-1:0] flag_eff_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [IDX_PORT_W-1:0] node_index;
    logic [6:0]            mnemonic;
    logic                  is_branch;
    logic                  is_deleted;
  } in_item_t;

  typedef struct packed {
    logic                  carry_dead;
    logic [IDX_PORT_W-1:0] carry_dead_index;
    logic                  overflow_dead;
    logic [IDX_PORT_W-1:0] overflow_dead_index;
    logic                  sign_dead;
    logic [IDX_PORT_W-1:0] sign_dead_index;
    logic                  zero_dead;
    logic [IDX_PORT_W-1:0] zero_dead_index;
    logic                  proc_overflow_dead;
    logic [IDX_PORT_W-1:0] proc_first_index;
    logic [IDX_PORT_W-1:0] proc_end_index;
    logic [1:0]            error_code;
  } out_item_t;

  // decoded mnemonic, passed from the decoder to the tracker
  typedef struct packed {
    flag_eff_t eff;
    logic      unknown;
  } mnem_dec_t;

  // effects of one group, index order carry, overflow, sign, zero
  function automatic flag_eff_t group_effects(input logic [3:0] grp);
    flag_eff_t e;
    case (grp)
      4'd1:    e = {EFF_WR,  EFF_WR,  EFF_WR,  EFF_WR };
      4'd2:    e = {EFF_RD,  EFF_RD,  EFF_RD,  EFF_IGN};
      4'd3:    e = {EFF_IGN, EFF_RD,  EFF_RD,  EFF_IGN};
      4'd4:    e = {EFF_RD,  EFF_IGN, EFF_IGN, EFF_IGN};
      4'd5:    e = {EFF_IGN, EFF_RD,  EFF_IGN, EFF_IGN};
      4'd6:    e = {EFF_RD,  EFF_IGN, EFF_IGN, EFF_RD };
      4'd7:    e = {EFF_IGN, EFF_IGN, EFF_IGN, EFF_RD };
      4'd8:    e = {EFF_IGN, EFF_IGN, EFF_RD,  EFF_IGN};
      4'd9:    e = {EFF_WR,  EFF_WR,  EFF_WR,  EFF_IGN};
      4'd10:   e = {EFF_IGN, EFF_IGN, EFF_WR,  EFF_RW };
      4'd11:   e = {EFF_IGN, EFF_IGN, EFF_WR,  EFF_WR };
      4'd12:   e = {EFF_IGN, EFF_IGN, EFF_IGN, EFF_WR };
      default: e = {EFF_IGN, EFF_IGN, EFF_IGN, EFF_IGN};
    endcase
    return e;
  endfunction

endpackage

[design/dfwm_if.sv]
// valid/ready channel interfaces for input items and result items
// depends on dfwm_pkg for the payload types
interface dfwm_in_if import dfwm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dfwm_out_if import dfwm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/dfwm_decode.sv]
// mnemonic decoder: dense mnemonic number to per-flag effects
// depends on dfwm_pkg
module dfwm_decode import dfwm_pkg::*; (
  input  logic [6:0] mnemonic,
  output mnem_dec_t  dec
);

  logic [3:0] grp;
  logic       unknown;

  // mnemonic ranges to effect groups
  always_comb begin
    unknown = 1'b0;
    unique case (mnemonic) inside
      [7'd0:7'd29]:  grp = 4'd0;
      [7'd30:7'd49]: grp = 4'd1;
      [7'd50:7'd51]: grp = 4'd2;
      [7'd52:7'd53]: grp = 4'd3;
      [7'd54:7'd56]: grp = 4'd4;
      [7'd57:7'd58]: grp = 4'd5;
      [7'd59:7'd60]: grp = 4'd6;
      [7'd61:7'd62]: grp = 4'd7;
      [7'd63:7'd64]: grp = 4'd8;
      [7'd65:7'd66]: grp = 4'd9;
      [7'd67:7'd68]: grp = 4'd10;
      [7'd69:7'd70]: grp = 4'd11;
      [7'd71:7'd72]: grp = 4'd12;
      default: begin
        grp     = 4'd0;
        unknown = 1'b1;
      end
    endcase
  end

  assign dec.eff     = group_effects(grp);
  assign dec.unknown = unknown;

endmodule

[design/dfwm_track.sv]
// last-writer tracking state and result computation for one item per cycle while fire is high
// depends on dfwm_pkg and dfwm_decode
module dfwm_track import dfwm_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t res
);

  localparam int WIDE_W = 48;

  logic [NUM_FLAGS-1:0]  lw_valid_r, lw_valid_nxt;
  logic [INDEX_BITS-1:0] lw_idx_r   [NUM_FLAGS];
  logic [INDEX_BITS-1:0] lw_idx_nxt [NUM_FLAGS];
  logic                  ovf_tested_r, ovf_tested_nxt;
  logic [INDEX_BITS-1:0] start_idx_r, start_idx_nxt;
  logic                  proc_seen_r, proc_seen_nxt;

  mnem_dec_t             dec;
  logic [WIDE_W-1:0]     idx_wide;
  logic [INDEX_BITS-1:0] idx;
  logic [WIDE_W-1:0]     end_wide;
  logic [NUM_FLAGS-1:0]  base_valid;
  logic [NUM_FLAGS-1:0]  dead;
  logic [IDX_PORT_W-1:0] dead_idx [NUM_FLAGS];
  logic [WIDE_W-1:0]     start_wide;
  logic                  is_insn;

  dfwm_decode u_decode (
    .mnemonic (item.mnemonic),
    .dec      (dec)
  );

  // index reduced or extended to the stored width
  assign idx_wide   = {{(WIDE_W-IDX_PORT_W){1'b0}}, item.node_index};
  assign idx        = idx_wide[INDEX_BITS-1:0];
  assign end_wide   = {{(WIDE_W-INDEX_BITS){1'b0}}, idx};
  assign start_wide = {{(WIDE_W-INDEX_BITS){1'b0}}, start_idx_r};
  assign is_insn    = !item.is_deleted && (item.cmd == CMD_INSN);

  // a branch drops all last writers before its own effects apply
  assign base_valid = (is_insn && item.is_branch) ? '0 : lw_valid_r;

  // per-flag effect on the last writer
  always_comb begin
    logic [WIDE_W-1:0] lw_wide;
    for (int f = 0; f < NUM_FLAGS; f++) begin
      lw_wide         = {{(WIDE_W-INDEX_BITS){1'b0}}, lw_idx_r[f]};
      lw_valid_nxt[f] = base_valid[f];
      lw_idx_nxt[f]   = lw_idx_r[f];
      dead[f]         = 1'b0;
      dead_idx[f]     = '0;
      case (dec.eff[f])
        EFF_RD: begin
          lw_valid_nxt[f] = 1'b0;
        end
        EFF_RW: begin
          lw_valid_nxt[f] = 1'b1;
          lw_idx_nxt[f]   = idx;
        end
        EFF_WR: begin
          dead[f]         = base_valid[f];
          dead_idx[f]     = base_valid[f] ? lw_wide[IDX_PORT_W-1:0] : '0;
          lw_valid_nxt[f] = 1'b1;
          lw_idx_nxt[f]   = idx;
        end
        default: begin
        end
      endcase
    end
  end

  // item kind selects the state update and the result
  always_comb begin
    res            = '0;
    ovf_tested_nxt = ovf_tested_r;
    start_idx_nxt  = start_idx_r;
    proc_seen_nxt  = proc_seen_r;
    if (!item.is_deleted) begin
      case (item.cmd)
        CMD_PROC_START: begin
          ovf_tested_nxt = 1'b0;
          start_idx_nxt  = idx;
          proc_seen_nxt  = 1'b1;
        end
        CMD_INSN: begin
          res.carry_dead          = dead[FLAG_CARRY];
          res.carry_dead_index    = dead_idx[FLAG_CARRY];
          res.overflow_dead       = dead[FLAG_OVERFLOW];
          res.overflow_dead_index = dead_idx[FLAG_OVERFLOW];
          res.sign_dead           = dead[FLAG_SIGN];
          res.sign_dead_index     = dead_idx[FLAG_SIGN];
          res.zero_dead           = dead[FLAG_ZERO];
          res.zero_dead_index     = dead_idx[FLAG_ZERO];
          res.error_code          = dec.unknown ? ERR_UNKNOWN_MNEM : ERR_NONE;
          if (item.is_branch && dec.eff[FLAG_OVERFLOW] == EFF_RD) begin
            ovf_tested_nxt = 1'b1;
          end
        end
        CMD_PROC_END: begin
          if (!proc_seen_r) begin
            res.error_code = ERR_END_NO_START;
          end else if (!ovf_tested_r) begin
            res.proc_overflow_dead = 1'b1;
            res.proc_first_index   = start_wide[IDX_PORT_W-1:0];
            res.proc_end_index     = end_wide[IDX_PORT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r   <= '0;
      ovf_tested_r <= 1'b0;
      proc_seen_r  <= 1'b0;
      start_idx_r  <= '0;
    end else if (fire) begin
      ovf_tested_r <= ovf_tested_nxt;
      proc_seen_r  <= proc_seen_nxt;
      start_idx_r  <= start_idx_nxt;
      if (is_insn) begin
        lw_valid_r <= lw_valid_nxt;
      end else if (!item.is_deleted && item.cmd == CMD_PROC_START) begin
        lw_valid_r <= '0;
      end
    end
  end

  // writer indexes, only read while their valid bit is set
  always_ff @(posedge clk) begin
    if (fire && is_insn) begin
      for (int f = 0; f < NUM_FLAGS; f++) begin
        lw_idx_r[f] <= lw_idx_nxt[f];
      end
    end
  end

endmodule

[design/dead_flag_write_marker_unit.sv]
// dead flag write marker: a stream of code items in, one result item per input item out
// ports:
//   in_chan  (sink)   code items: cmd, node_index, mnemonic, is_branch, is_deleted
//   out_chan (source) result items: dead carry/overflow/sign/zero writes with the
//                     writer indexes, a whole-procedure overflow range, error_code
// every accepted input item produces exactly one result item, in order
// path: an accepted item passes the input register, then the result register, which is
//   loaded by one pass of table lookup and last-writer update
// throughput: one item per cycle; the two registers form a pipeline that moves on
//   whenever the result register is empty or being taken
// stall: while out_chan.ready is low the result is held, the input register still
//   takes one more item, and after that in_chan.ready drops
// reset: synchronous active-low rst_n empties both registers and clears all last
//   writers, the overflow-tested mark and the procedure-seen mark
// depends on dfwm_pkg, dfwm_if, dfwm_track and the assertion macro header
module dead_flag_write_marker_unit import dfwm_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  dfwm_in_if.sink           in_chan,
  dfwm_out_if.source        out_chan
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t res;
  logic      advance;
  logic      fire;

  // pipeline control
  assign advance       = !out_valid_r || out_chan.ready;
  assign fire          = in_valid_r && advance;
  assign in_chan.ready = !in_valid_r || advance;
  assign out_valid_nxt = fire ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r <= in_chan.data;
    end
  end

  dfwm_track #(
    .INDEX_BITS (INDEX_BITS)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

  `include "dead_flag_write_marker_unit_assert.svh"

  // a procedure end without start reports no procedure range and no dead carry or zero write
  `DFWM_ASSERT_IMPLY(a_err_alone, clk, rst_n,
    out_valid_r && out_item_r.error_code == ERR_END_NO_START,
    !out_item_r.proc_overflow_dead && !out_item_r.carry_dead && !out_item_r.zero_dead)

  // a procedure range never comes with a dead overflow or sign write or an error code
  `DFWM_ASSERT_IMPLY(a_dead_vs_range, clk, rst_n,
    out_valid_r && out_item_r.proc_overflow_dead,
    !out_item_r.overflow_dead && !out_item_r.sign_dead && out_item_r.error_code == ERR_NONE)

  // a held item in the input register is not lost while the output stalls
  `DFWM_ASSERT_IMPLY(a_stall_hold, clk, rst_n,
    in_valid_r && !advance, !in_chan.ready && out_valid_r)

  // reset empties the result register and the input register
  `DFWM_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid_r && !in_valid_r)

endmodule
